// ===== src/ihx_pkg.sv =====
// Shared types, character codes and helpers for the Intel HEX record encoder.
package ihx_pkg;

    localparam int CNT_W = 6;

    localparam logic [6:0] CHAR_COLON   = 7'h3A;
    localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

    localparam logic REC_DATA = 1'b0;
    localparam logic REC_END  = 1'b1;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // One record handed from the front to the back.
    typedef struct packed {
        logic             rec_type;
        logic [15:0]      rec_addr;
        logic [CNT_W-1:0] count;
        logic             bank;
        logic             last;
    } desc_t;

    // Back tells the front that a buffer bank has been read out.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            hex_char = 7'h30 + 7'(nib);
        end
        else
        begin
            hex_char = 7'h37 + 7'(nib);
        end
    endfunction

endpackage

// ===== src/ihx_ram.sv =====
// Two-bank record byte store: one write port, one registered read port.
module ihx_ram
#(
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/ihx_fifo.sv =====
// Two-entry record queue between the front and the back.
module ihx_fifo
    import ihx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_data,
    input  logic  pop,
    output desc_t pop_data,
    output logic  full,
    output logic  empty
);

    desc_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  level_reg;
    logic [1:0]  level_next;

    assign full     = (level_reg == 2'd2);
    assign empty    = (level_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        level_next  = level_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== src/ihx_front.sv =====
// Front: accept items, gather bytes into a bank, queue closed records.
module ihx_front
    import ihx_pkg::*;
#(
    parameter int RECORD_BYTES = 32,
    parameter int IDX_W        = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             stall,
    input  logic             cmd,
    input  logic [7:0]       byte_value,
    input  logic [15:0]      address,
    input  logic [15:0]      end_address,
    output logic             push,
    output desc_t            push_data,
    input  logic             q_full,
    input  bank_release_t    release_in,
    output logic             wr_en,
    output logic [IDX_W:0]   wr_addr,
    output logic [7:0]       wr_data
);

    localparam int FILL_W = $clog2(RECORD_BYTES + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RECORD_BYTES);

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [15:0]       block_addr_reg;
    logic [15:0]       block_addr_next;
    logic [16:0]       next_addr_reg;
    logic [16:0]       next_addr_next;
    logic              cur_bank_reg;
    logic              cur_bank_next;
    logic [1:0]        busy_reg;
    logic [1:0]        busy_next;

    logic start;
    logic close;
    logic wbank;
    logic ok;
    logic take;
    logic flush_data;

    always_comb
    begin
        start      = (fill_reg == '0);
        close      = !start && (({1'b0, address} != next_addr_reg) || (fill_reg == FILL_FULL));
        wbank      = close ? ~cur_bank_reg : cur_bank_reg;
        if (cmd == CMD_BYTE)
        begin
            ok = !busy_reg[wbank] && (!close || !q_full);
        end
        else
        begin
            ok = start && !q_full;
        end
        stall      = !ok;
        take       = valid && ok;
        // First half of a flush with pending bytes: queue the data record only.
        flush_data = valid && (cmd == CMD_FLUSH) && !start && !q_full;

        push_data.rec_type = REC_DATA;
        push_data.rec_addr = block_addr_reg;
        push_data.count    = CNT_W'(fill_reg);
        push_data.bank     = cur_bank_reg;
        push_data.last     = (cmd == CMD_BYTE);
        push = 1'b0;

        wr_en   = take && (cmd == CMD_BYTE);
        wr_addr = {wbank, (start || close) ? IDX_W'(0) : fill_reg[IDX_W-1:0]};
        wr_data = byte_value;

        fill_next       = fill_reg;
        block_addr_next = block_addr_reg;
        next_addr_next  = next_addr_reg;
        cur_bank_next   = cur_bank_reg;
        busy_next       = busy_reg;

        if (release_in.valid)
        begin
            busy_next[release_in.bank] = 1'b0;
        end

        if (take && (cmd == CMD_BYTE))
        begin
            push          = close;
            cur_bank_next = wbank;
            if (close)
            begin
                busy_next[cur_bank_reg] = 1'b1;
            end
            if (start || close)
            begin
                fill_next       = FILL_W'(1);
                block_addr_next = address;
                next_addr_next  = {1'b0, address} + 17'd1;
            end
            else
            begin
                fill_next      = fill_reg + 1'b1;
                next_addr_next = next_addr_reg + 17'd1;
            end
        end
        else if (flush_data)
        begin
            push                    = 1'b1;
            busy_next[cur_bank_reg] = 1'b1;
            cur_bank_next           = ~cur_bank_reg;
            fill_next               = '0;
        end
        else if (take)
        begin
            push               = 1'b1;
            push_data.rec_type = REC_END;
            push_data.rec_addr = end_address;
            push_data.count    = '0;
            push_data.last     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            block_addr_reg <= '0;
            next_addr_reg  <= '0;
            cur_bank_reg   <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            fill_reg       <= fill_next;
            block_addr_reg <= block_addr_next;
            next_addr_reg  <= next_addr_next;
            cur_bank_reg   <= cur_bank_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

// ===== src/ihx_back.sv =====
// Back: walk one queued record and emit its ASCII pieces.
module ihx_back
    import ihx_pkg::*;
#(
    parameter int IDX_W = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  desc_t         q_data,
    output logic          pop,
    output bank_release_t release_out,
    output logic [IDX_W:0] rd_addr,
    input  logic [7:0]    rd_data,
    output logic          valid,
    input  logic          stall,
    output logic [6:0]    char_first,
    output logic [6:0]    char_second,
    output logic [1:0]    char_count,
    output logic          last
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COLON,
        ST_COUNT,
        ST_ADDRH,
        ST_ADDRL,
        ST_TYPE,
        ST_DATA,
        ST_CSUM,
        ST_NEWLINE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [15:0]      addr_reg;
    logic [15:0]      addr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             type_reg;
    logic             type_next;
    logic             bank_reg;
    logic             bank_next;
    logic             last_reg;
    logic             last_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic             valid_reg;
    logic             valid_next;
    logic [6:0]       first_reg;
    logic [6:0]       first_next;
    logic [6:0]       second_reg;
    logic [6:0]       second_next;
    logic [1:0]       count_out_reg;
    logic [1:0]       count_out_next;
    logic             last_out_reg;
    logic             last_out_next;

    logic       adv;
    logic       emit;
    logic [7:0] pair;
    logic       single;
    logic [6:0] single_char;

    assign valid       = valid_reg;
    assign char_first  = first_reg;
    assign char_second = second_reg;
    assign char_count  = count_out_reg;
    assign last        = last_out_reg;
    // Read one ahead so rd_data always holds the byte at idx_reg.
    assign rd_addr     = {bank_next, idx_next[IDX_W-1:0]};

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        type_next      = type_reg;
        bank_next      = bank_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        valid_next     = valid_reg && stall;
        first_next     = first_reg;
        second_next    = second_reg;
        count_out_next = count_out_reg;
        last_out_next  = last_out_reg;

        adv         = !valid_reg || !stall;
        emit        = 1'b0;
        single      = 1'b0;
        single_char = CHAR_COLON;
        pair        = 8'h00;
        pop         = 1'b0;
        release_out = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    addr_next  = q_data.rec_addr;
                    count_next = q_data.count;
                    type_next  = q_data.rec_type;
                    bank_next  = q_data.bank;
                    last_next  = q_data.last;
                    idx_next   = '0;
                    sum_next   = 8'(q_data.count) + q_data.rec_addr[15:8]
                               + q_data.rec_addr[7:0] + 8'(q_data.rec_type);
                    state_next = ST_COLON;
                end
            end
            ST_COLON:
            begin
                emit        = adv;
                single      = 1'b1;
                single_char = CHAR_COLON;
                if (adv)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                emit = adv;
                pair = 8'(count_reg);
                if (adv)
                begin
                    state_next = ST_ADDRH;
                end
            end
            ST_ADDRH:
            begin
                emit = adv;
                pair = addr_reg[15:8];
                if (adv)
                begin
                    state_next = ST_ADDRL;
                end
            end
            ST_ADDRL:
            begin
                emit = adv;
                pair = addr_reg[7:0];
                if (adv)
                begin
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                emit = adv;
                pair = 8'(type_reg);
                if (adv)
                begin
                    state_next = (count_reg == '0) ? ST_CSUM : ST_DATA;
                end
            end
            ST_DATA:
            begin
                emit = adv;
                pair = rd_data;
                if (adv)
                begin
                    sum_next = sum_reg + rd_data;
                    if (idx_reg == count_reg - 1'b1)
                    begin
                        release_out.valid = 1'b1;
                        release_out.bank  = bank_reg;
                        state_next        = ST_CSUM;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_CSUM:
            begin
                emit = adv;
                pair = 8'h00 - sum_reg;
                if (adv)
                begin
                    state_next = ST_NEWLINE;
                end
            end
            ST_NEWLINE:
            begin
                emit        = adv;
                single      = 1'b1;
                single_char = CHAR_NEWLINE;
                if (adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            valid_next = 1'b1;
            if (single)
            begin
                first_next     = single_char;
                second_next    = 7'h00;
                count_out_next = 2'd1;
                last_out_next  = (state_reg == ST_NEWLINE) && last_reg;
            end
            else
            begin
                first_next     = hex_char(pair[7:4]);
                second_next    = hex_char(pair[3:0]);
                count_out_next = 2'd2;
                last_out_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            addr_reg      <= '0;
            count_reg     <= '0;
            type_reg      <= REC_DATA;
            bank_reg      <= 1'b0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            valid_reg     <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            count_out_reg <= '0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            type_reg      <= type_next;
            bank_reg      <= bank_next;
            last_reg      <= last_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            valid_reg     <= valid_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            count_out_reg <= count_out_next;
            last_out_reg  <= last_out_next;
        end
    end

endmodule

// ===== src/intel_hex_record_encoder.sv =====
// Top level of the Intel HEX record encoder: front, record queue, byte store, back.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-----------------------------------------
//   in      | input     | in_valid/in_stall  | cmd, byte_value, address, end_address
//   out     | output    | out_valid/out_stall| char_first, char_second, char_count, last
//
// Flow: a byte that extends the open record is taken directly; a flush with bytes pending
//   is taken as a data record, then an end record. A record of N bytes is N + 7 pieces,
//   emitted one per cycle unless out_stall holds a piece, after a load in the idle state.
// Stalls: in_stall rises if an item must queue a record and the two-entry queue is full,
//   if a byte needs the bank the back is still reading, or on a flush with bytes pending.
// Reset: rst_n clears all control state at once; no clearing pass is needed.
module intel_hex_record_encoder
    import ihx_pkg::*;
#(
    parameter int RECORD_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  byte_value,
    input  logic [15:0] address,
    input  logic [15:0] end_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  char_first,
    output logic [6:0]  char_second,
    output logic [1:0]  char_count,
    output logic        last
);

    // Byte index within one bank; each record bank holds up to RECORD_BYTES bytes.
    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    logic          q_push;
    desc_t         q_push_data;
    logic          q_pop;
    desc_t         q_pop_data;
    logic          q_full;
    logic          q_empty;
    bank_release_t bank_release;
    logic          wr_en;
    logic [IDX_W:0] wr_addr;
    logic [7:0]    wr_data;
    logic [IDX_W:0] rd_addr;
    logic [7:0]    rd_data;

    // Classify each item and fill the current bank; hand closed records to the queue.
    ihx_front
    #(
        .RECORD_BYTES (RECORD_BYTES),
        .IDX_W        (IDX_W)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (in_valid),
        .stall       (in_stall),
        .cmd         (cmd),
        .byte_value  (byte_value),
        .address     (address),
        .end_address (end_address),
        .push        (q_push),
        .push_data   (q_push_data),
        .q_full      (q_full),
        .release_in  (bank_release),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    // Decouple record acceptance from character output.
    ihx_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Two banks: the front fills one while the back reads the other.
    ihx_ram
    #(
        .ADDR_W (IDX_W + 1)
    )
    u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Emit colon, header pairs, data pairs, checksum and newline.
    ihx_back
    #(
        .IDX_W (IDX_W)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_pop_data),
        .pop         (q_pop),
        .release_out (bank_release),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .valid       (out_valid),
        .stall       (out_stall),
        .char_first  (char_first),
        .char_second (char_second),
        .char_count  (char_count),
        .last        (last)
    );

endmodule

// ===== src/ihx_checker.sv =====
// Port-level checks for the Intel HEX record encoder, bound to the top level.
module ihx_checker
    import ihx_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] char_first,
    input logic [6:0] char_second,
    input logic [1:0] char_count,
    input logic       last
);

    // Hold a stalled piece.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_first)
            && $stable(char_second) && $stable(char_count) && $stable(last))
        else $error("stalled output piece changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_count == 2'd1) || (char_count == 2'd2))
        else $error("piece carries neither one nor two characters");

    // Single characters are only the record mark or the line end, with no second char.
    a_single_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_count == 2'd1) |->
            (char_second == 7'h00)
            && ((char_first == CHAR_COLON) || (char_first == CHAR_NEWLINE)))
        else $error("bad single-character piece");

    // The final piece of an item always closes a line.
    a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (char_count == 2'd1) && (char_first == CHAR_NEWLINE))
        else $error("item ended on a piece other than newline");

    // A record mark never comes straight after an accepted hex pair.
    a_colon_after_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (char_count == 2'd2) |=>
            !(out_valid && (char_count == 2'd1) && (char_first == CHAR_COLON))
            || $past(char_first == CHAR_NEWLINE))
        else $error("record mark in the middle of a record");

endmodule

bind intel_hex_record_encoder ihx_checker u_ihx_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_first  (char_first),
    .char_second (char_second),
    .char_count  (char_count),
    .last        (last)
);
